>>> hdl/mkdr_pkg.sv
package mkdr_pkg;

	// register map (word index = paddr[3:2])
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_HOLD     = 2'd1;
	localparam logic [1:0] REG_REPEAT   = 2'd2;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [15:0] HOLD_RESET     = 16'd1000;
	localparam logic [15:0] REPEAT_RESET   = 16'd200;

	// scan-to-state queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// key index 0..15, bit 4 set means no key
	localparam logic [4:0] KEY_NONE = 5'd16;

	typedef struct packed {
		logic [3:0]  cols_all_rows_low;
		logic [15:0] cols_per_row;
		logic [31:0] now_ms;
	} poll_word_t;

	typedef struct packed {
		logic       key_valid;
		logic [7:0] key_code;
	} report_word_t;

	// decoded poll as it sits in the queue
	typedef struct packed {
		logic [4:0]  key;
		logic [31:0] now_ms;
	} scan_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [15:0] debounce_time_ms;
		logic [15:0] hold_time_ms;
		logic [15:0] repeat_time_ms;
	} cfg_t;

	typedef enum logic [5:0] {
		MODE_UP       = 6'b000001,
		MODE_DEBOUNCE = 6'b000010,
		MODE_PRESSED  = 6'b000100,
		MODE_DOWN     = 6'b001000,
		MODE_HELD     = 6'b010000,
		MODE_RELEASED = 6'b100000
	} mode_t;

	// keypad legend, row-major: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
	function automatic logic [7:0] key_ascii(input logic [3:0] idx);
		logic [7:0] code;
		case (idx)
			4'd0:    code = 8'h31;
			4'd1:    code = 8'h32;
			4'd2:    code = 8'h33;
			4'd3:    code = 8'h41;
			4'd4:    code = 8'h34;
			4'd5:    code = 8'h35;
			4'd6:    code = 8'h36;
			4'd7:    code = 8'h42;
			4'd8:    code = 8'h37;
			4'd9:    code = 8'h38;
			4'd10:   code = 8'h39;
			4'd11:   code = 8'h43;
			4'd12:   code = 8'h2A;
			4'd13:   code = 8'h30;
			4'd14:   code = 8'h23;
			4'd15:   code = 8'h44;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

>>> hdl/matrix_keypad_debounce_repeat.sv
// 4x4 matrix keypad decoder with debounce and auto-repeat. Each poll word
// carries one keypad snapshot and the millisecond time it was taken; every
// poll yields exactly one report word, in order, with key_valid set when a
// key is reported (ASCII in key_code, else key_code is zero). One poll is
// taken per clock while poll_stall is low; a report is registered after
// its poll leaves the queue. The front end decodes the key combinationally
// into a two-word queue; the back end steps the debounce state machine once
// per popped word and holds its result in an output register, so a stalled
// report side backs up only after the queue fills. Timing registers sit on
// an APB port at byte offsets 0 (debounce), 4 (hold) and 8 (repeat); write
// them only while no poll is in flight.
module matrix_keypad_debounce_repeat (
	input  logic                                clk,
	input  logic                                arst_n,
	// poll side
	input  logic                                poll_valid,
	output logic                                poll_stall,
	input  mkdr_pkg::poll_word_t                poll,
	// report side
	output logic                                report_valid,
	input  logic                                report_stall,
	output mkdr_pkg::report_word_t              report,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mkdr_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	mkdr_pkg::cfg_t        cfg_q;
	mkdr_pkg::queue_stat_t q_stat;
	mkdr_pkg::scan_t       push_data;
	mkdr_pkg::scan_t       pop_data;
	logic                  push;
	logic                  pop;
	logic                  reg_wr;
	logic [1:0]            reg_idx;

	// ---- register file ----
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time_ms <= mkdr_pkg::DEBOUNCE_RESET;
			cfg_q.hold_time_ms     <= mkdr_pkg::HOLD_RESET;
			cfg_q.repeat_time_ms   <= mkdr_pkg::REPEAT_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				mkdr_pkg::REG_DEBOUNCE: cfg_q.debounce_time_ms <= pwdata[15:0];
				mkdr_pkg::REG_HOLD:     cfg_q.hold_time_ms     <= pwdata[15:0];
				mkdr_pkg::REG_REPEAT:   cfg_q.repeat_time_ms   <= pwdata[15:0];
				default: ;  // unmapped word: ignored
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mkdr_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_time_ms};
			mkdr_pkg::REG_HOLD:     prdata = {16'd0, cfg_q.hold_time_ms};
			mkdr_pkg::REG_REPEAT:   prdata = {16'd0, cfg_q.repeat_time_ms};
			default:                prdata = 32'd0;
		endcase
	end

	// ---- front: scan decode ----
	mkdr_front u_front (
		.poll_valid (poll_valid),
		.poll_stall (poll_stall),
		.poll       (poll),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	// ---- decoupling queue ----
	mkdr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// ---- back: debounce / repeat state machine ----
	mkdr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_stat       (q_stat),
		.pop_data     (pop_data),
		.pop          (pop),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report)
	);

	// ---- checks ----
	// back end never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// a full queue refuses polls
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("push into full queue");

	// a report without a key carries code zero
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && !report.key_valid) |-> (report.key_code == 8'h00))
		else $error("key_code set without key_valid");

	// a reported key always carries a legend code
	a_code_set: assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && report.key_valid) |-> (report.key_code != 8'h00))
		else $error("key reported with empty code");

endmodule

>>> hdl/mkdr_front.sv
module mkdr_front (
	input  logic                 poll_valid,
	output logic                 poll_stall,
	input  mkdr_pkg::poll_word_t poll,
	input  mkdr_pkg::queue_stat_t q_stat,
	output logic                 push,
	output mkdr_pkg::scan_t      push_data
);

	logic       col_found;
	logic [1:0] col_idx;
	logic       row_found;
	logic [1:0] row_idx;

	// column: highest low bit with all rows grounded
	always_comb begin
		col_found = 1'b0;
		col_idx   = 2'd0;
		for (int c = 0; c < 4; c++) begin
			if (!poll.cols_all_rows_low[c]) begin
				col_found = 1'b1;
				col_idx   = 2'(c);
			end
		end
	end

	// row: first row whose nibble shows a low column
	always_comb begin
		row_found = 1'b0;
		row_idx   = 2'd0;
		for (int r = 3; r >= 0; r--) begin
			if (poll.cols_per_row[4*r +: 4] != 4'hF) begin
				row_found = 1'b1;
				row_idx   = 2'(r);
			end
		end
	end

	assign push_data.key    = (col_found && row_found) ? {1'b0, row_idx, col_idx}
	                                                   : mkdr_pkg::KEY_NONE;
	assign push_data.now_ms = poll.now_ms;
	assign poll_stall       = q_stat.full;
	assign push             = poll_valid && !q_stat.full;

endmodule

>>> hdl/mkdr_queue.sv
module mkdr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mkdr_pkg::scan_t       push_data,
	input  logic                  pop,
	output mkdr_pkg::scan_t       pop_data,
	output mkdr_pkg::queue_stat_t q_stat
);

	mkdr_pkg::scan_t                    ent_q [mkdr_pkg::QUEUE_DEPTH];
	logic [mkdr_pkg::QUEUE_AW-1:0]      wr_ptr_q;
	logic [mkdr_pkg::QUEUE_AW-1:0]      rd_ptr_q;
	logic [mkdr_pkg::QUEUE_CW-1:0]      count_q;

	function automatic logic [mkdr_pkg::QUEUE_AW-1:0] ptr_inc(
		input logic [mkdr_pkg::QUEUE_AW-1:0] p);
		logic [mkdr_pkg::QUEUE_AW-1:0] n;
		if (p == mkdr_pkg::QUEUE_AW'(mkdr_pkg::QUEUE_DEPTH - 1))
			n = '0;
		else
			n = p + 1'b1;
		return n;
	endfunction

	assign q_stat.full  = (count_q == mkdr_pkg::QUEUE_CW'(mkdr_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/mkdr_back.sv
module mkdr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mkdr_pkg::cfg_t         cfg,
	input  mkdr_pkg::queue_stat_t  q_stat,
	input  mkdr_pkg::scan_t        pop_data,
	output logic                   pop,
	output logic                   report_valid,
	input  logic                   report_stall,
	output mkdr_pkg::report_word_t report
);

	mkdr_pkg::mode_t        mode_q, mode_d;
	logic [4:0]             sensed_q, sensed_d;
	logic [31:0]            stamp_q, stamp_d;
	logic                   fire;
	logic [31:0]            age;
	logic                   key_none;
	logic                   key_same;
	logic                   report_valid_q;
	mkdr_pkg::report_word_t report_q;
	mkdr_pkg::report_word_t report_d;

	assign pop      = !q_stat.empty && (!report_valid_q || !report_stall);
	assign age      = pop_data.now_ms - stamp_q;   // wraps mod 2^32
	assign key_none = (pop_data.key == mkdr_pkg::KEY_NONE);
	assign key_same = (pop_data.key == sensed_q);

	always_comb begin
		mode_d   = mode_q;
		sensed_d = sensed_q;
		stamp_d  = stamp_q;
		fire     = 1'b0;
		case (mode_q)
			mkdr_pkg::MODE_UP: begin
				if (!key_none) begin
					sensed_d = pop_data.key;
					stamp_d  = pop_data.now_ms;
					mode_d   = mkdr_pkg::MODE_DEBOUNCE;
				end else begin
					sensed_d = mkdr_pkg::KEY_NONE;
				end
			end
			mkdr_pkg::MODE_DEBOUNCE: begin
				if (key_none) begin
					mode_d   = mkdr_pkg::MODE_UP;
					sensed_d = mkdr_pkg::KEY_NONE;
				end else if (key_same) begin
					if (age > {16'd0, cfg.debounce_time_ms}) begin
						mode_d  = mkdr_pkg::MODE_PRESSED;
						stamp_d = pop_data.now_ms;
						fire    = 1'b1;
					end
				end else begin
					stamp_d  = pop_data.now_ms;
					sensed_d = pop_data.key;
				end
			end
			mkdr_pkg::MODE_PRESSED: begin
				if (key_none)
					mode_d = mkdr_pkg::MODE_RELEASED;
				else if (key_same)
					mode_d = mkdr_pkg::MODE_DOWN;
				else
					mode_d = mkdr_pkg::MODE_DEBOUNCE;
				stamp_d = pop_data.now_ms;
			end
			mkdr_pkg::MODE_DOWN: begin
				if (key_same) begin
					if (age > {16'd0, cfg.hold_time_ms}) begin
						mode_d  = mkdr_pkg::MODE_HELD;
						stamp_d = pop_data.now_ms;
					end
				end else begin
					mode_d  = mkdr_pkg::MODE_RELEASED;
					stamp_d = pop_data.now_ms;
				end
			end
			mkdr_pkg::MODE_HELD: begin
				if (!key_same) begin
					mode_d  = mkdr_pkg::MODE_RELEASED;
					stamp_d = pop_data.now_ms;
					fire    = 1'b1;
				end else if (age > {16'd0, cfg.repeat_time_ms}) begin
					stamp_d = pop_data.now_ms;
					fire    = 1'b1;
				end
			end
			mkdr_pkg::MODE_RELEASED: begin
				if (key_none) begin
					mode_d = mkdr_pkg::MODE_UP;
				end else begin
					mode_d   = mkdr_pkg::MODE_DEBOUNCE;
					sensed_d = pop_data.key;
					stamp_d  = pop_data.now_ms;
				end
			end
			default: begin
				mode_d   = mkdr_pkg::MODE_UP;
				sensed_d = mkdr_pkg::KEY_NONE;
				stamp_d  = '0;
			end
		endcase
	end

	always_comb begin
		if (fire && !sensed_d[4]) begin
			report_d.key_valid = 1'b1;
			report_d.key_code  = mkdr_pkg::key_ascii(sensed_d[3:0]);
		end else begin
			report_d.key_valid = 1'b0;
			report_d.key_code  = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= mkdr_pkg::MODE_UP;
			sensed_q       <= mkdr_pkg::KEY_NONE;
			stamp_q        <= '0;
			report_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q   <= mode_d;
				sensed_q <= sensed_d;
				stamp_q  <= stamp_d;
			end
			if (pop)
				report_valid_q <= 1'b1;
			else if (!report_stall)
				report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			report_q <= report_d;
		end
	end

	assign report_valid = report_valid_q;
	assign report       = report_q;

endmodule
